// File: sv/scsf_pkg.sv
// ----------------------------------------------------------------------------
// scsf_pkg: shared types and constants of the source comment/string filter
// Mode codes, result kinds, status codes, character constants and defaults.
// ----------------------------------------------------------------------------
package scsf_pkg;

   // default sizes
   localparam int unsigned PROGRAM_BYTES_DEF = 65536;
   localparam int unsigned STRING_BYTES_DEF  = 256;
   localparam int unsigned STRING_SLOTS_DEF  = 256;

   // result queue
   localparam int unsigned MAX_RES    = 4;
   localparam int unsigned FIFO_DEPTH = 8;
   localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
   localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [7:0] {
      MODE_NORMAL  = 8'b0000_0001,
      MODE_BLANK   = 8'b0000_0010,
      MODE_SLASH   = 8'b0000_0100,
      MODE_COMMENT = 8'b0000_1000,
      MODE_STAR    = 8'b0001_0000,
      MODE_STRING  = 8'b0010_0000,
      MODE_ESC     = 8'b0100_0000,
      MODE_OCT     = 8'b1000_0000
   } mode_type;

   // result kinds
   localparam logic [1:0] KIND_PROG = 2'd0;
   localparam logic [1:0] KIND_STR  = 2'd1;
   localparam logic [1:0] KIND_SEND = 2'd2;
   localparam logic [1:0] KIND_END  = 2'd3;

   // status codes
   localparam logic [7:0] STAT_OK       = 8'd0;
   localparam logic [7:0] STAT_UNBAL    = 8'd1;
   localparam logic [7:0] STAT_QUOTE    = 8'd2;
   localparam logic [7:0] STAT_OVERSIZE = 8'd3;
   localparam logic [7:0] STAT_TOO_MANY = 8'd4;

   // characters
   localparam logic [7:0] CHR_NUL   = 8'h00;
   localparam logic [7:0] CHR_TAB   = 8'h09;
   localparam logic [7:0] CHR_NL    = 8'h0A;
   localparam logic [7:0] CHR_CR    = 8'h0D;
   localparam logic [7:0] CHR_CTRLZ = 8'h1A;
   localparam logic [7:0] CHR_SPACE = 8'h20;
   localparam logic [7:0] CHR_QUOTE = 8'h22;
   localparam logic [7:0] CHR_STAR  = 8'h2A;
   localparam logic [7:0] CHR_SLASH = 8'h2F;
   localparam logic [7:0] CHR_ZERO  = 8'h30;
   localparam logic [7:0] CHR_SEVEN = 8'h37;
   localparam logic [7:0] CHR_BSL   = 8'h5C;
   localparam logic [7:0] CHR_N     = 8'h6E;
   localparam logic [7:0] CHR_T     = 8'h74;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] value;
      logic       last;
   } res_type;

endpackage

// File: sv/scsf_req_if.sv
// ----------------------------------------------------------------------------
// scsf_req_if: source byte channel
// Valid/ready channel carrying one source byte or an end-of-input mark.
// ----------------------------------------------------------------------------
interface scsf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] src_byte;
   logic       end_of_input;

   modport source (output valid, output src_byte, output end_of_input, input ready);
   modport sink   (input valid, input src_byte, input end_of_input, output ready);
endinterface

// File: sv/scsf_rsp_if.sv
// ----------------------------------------------------------------------------
// scsf_rsp_if: result channel
// Valid/ready channel carrying one result word: kind, value and last flag.
// ----------------------------------------------------------------------------
interface scsf_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] out_kind;
   logic [7:0] out_value;
   logic       out_last;

   modport source (output valid, output out_kind, output out_value, output out_last,
                   input ready);
   modport sink   (input valid, input out_kind, input out_value, input out_last,
                   output ready);
endinterface

// File: sv/source_comment_string_filter.sv
// ----------------------------------------------------------------------------
// source_comment_string_filter: comment stripper and string escape decoder
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    src_byte[7:0], end_of_input
//   rsp      out  valid/ready    out_kind[1:0], out_value[7:0], out_last
//
// One source byte is taken per cycle; its up to four result words are
// written into an eight-word result queue in the same cycle.
// The queue drains one word per cycle while rsp.ready is high;
// req.ready drops while fewer than four queue slots are free.
// Reset (synchronous) returns the scanner to normal text and empties the queue.
// After an error or the terminator every further byte is taken and dropped.
// ----------------------------------------------------------------------------
module source_comment_string_filter #(
   parameter int unsigned PROGRAM_BYTES = scsf_pkg::PROGRAM_BYTES_DEF,
   parameter int unsigned STRING_BYTES  = scsf_pkg::STRING_BYTES_DEF,
   parameter int unsigned STRING_SLOTS  = scsf_pkg::STRING_SLOTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   scsf_req_if.sink   req,
   scsf_rsp_if.source rsp
);
   import scsf_pkg::*;

   localparam int unsigned PC_W = $clog2(PROGRAM_BYTES + 4);
   localparam int unsigned RC_W = $clog2(STRING_BYTES);
   localparam int unsigned SU_W = $clog2(STRING_SLOTS + 1);

   // scanner state
   mode_type          mode_ff, mode_in;
   logic [PC_W-1:0]   pc_ff, pc_in;
   logic [RC_W-1:0]   rc_ff, rc_in;
   logic [SU_W-1:0]   su_ff, su_in;
   logic [7:0]        ov_ff, ov_in;
   logic [1:0]        odl_ff, odl_in;
   logic              held_ff, held_in;
   logic              stop_ff, stop_in;

   // result queue
   res_type           fifo_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic              accept;
   logic              pop;
   logic [7:0]        c;
   logic [1:0]        res_kind [MAX_RES];
   logic [7:0]        res_val  [MAX_RES];
   logic [2:0]        n_res;
   logic [2:0]        n_push;
   logic              err_hit;
   logic [7:0]        err_code;
   logic              do_norm;
   logic              do_str;
   logic              raw_full;

   assign accept = req.valid && req.ready;
   assign pop    = rsp.valid && rsp.ready;
   assign c      = req.src_byte;

   assign req.ready = (count_ff <= CNT_W'(FIFO_DEPTH - MAX_RES));
   assign rsp.valid = (count_ff != '0);
   assign rsp.out_kind  = fifo_ff[rd_ptr_ff].kind;
   assign rsp.out_value = fifo_ff[rd_ptr_ff].value;
   assign rsp.out_last  = fifo_ff[rd_ptr_ff].last;

   always_comb begin
      mode_in  = mode_ff;
      pc_in    = pc_ff;
      rc_in    = rc_ff;
      su_in    = su_ff;
      ov_in    = ov_ff;
      odl_in   = odl_ff;
      held_in  = held_ff;
      stop_in  = stop_ff;
      n_res    = 3'd0;
      err_hit  = 1'b0;
      err_code = STAT_OK;
      do_norm  = 1'b0;
      do_str   = 1'b0;
      raw_full = 1'b0;
      for (int i = 0; i < MAX_RES; i++) begin
         res_kind[i] = KIND_PROG;
         res_val[i]  = 8'd0;
      end

      if (accept && !stop_ff) begin
         if (req.end_of_input) begin
            unique case (mode_ff)
               MODE_COMMENT, MODE_STAR: begin
                  err_hit  = 1'b1;
                  err_code = STAT_UNBAL;
               end
               MODE_STRING, MODE_ESC, MODE_OCT: begin
                  err_hit  = 1'b1;
                  err_code = STAT_QUOTE;
               end
               MODE_SLASH: begin
                  res_kind[n_res[1:0]] = KIND_PROG;
                  res_val[n_res[1:0]]  = CHR_SLASH;
                  n_res = n_res + 3'd1;
                  pc_in = pc_in + PC_W'(1);
               end
               default: ;
            endcase
            if (!err_hit) begin
               res_kind[n_res[1:0]] = KIND_END;
               res_val[n_res[1:0]]  = STAT_OK;
               n_res = n_res + 3'd1;
            end
            held_in = 1'b0;
            stop_in = 1'b1;
         end else begin
            if (held_ff) begin
               res_kind[n_res[1:0]] = KIND_PROG;
               res_val[n_res[1:0]]  = CHR_CTRLZ;
               n_res   = n_res + 3'd1;
               held_in = 1'b0;
            end

            unique case (mode_ff)
               MODE_NORMAL, MODE_BLANK: do_norm = 1'b1;
               MODE_SLASH: begin
                  if (c == CHR_STAR) begin
                     mode_in = MODE_COMMENT;
                  end else begin
                     res_kind[n_res[1:0]] = KIND_PROG;
                     res_val[n_res[1:0]]  = CHR_SLASH;
                     n_res   = n_res + 3'd1;
                     pc_in   = pc_in + PC_W'(1);
                     mode_in = MODE_NORMAL;
                     do_norm = 1'b1;
                  end
               end
               MODE_COMMENT: begin
                  if (c == CHR_STAR) begin
                     mode_in = MODE_STAR;
                  end else if (c == CHR_NL) begin
                     res_kind[n_res[1:0]] = KIND_PROG;
                     res_val[n_res[1:0]]  = CHR_NL;
                     n_res = n_res + 3'd1;
                     pc_in = pc_in + PC_W'(1);
                  end
               end
               MODE_STAR: begin
                  // a run of stars keeps the comment closable
                  if (c == CHR_SLASH) begin
                     mode_in = MODE_NORMAL;
                  end else if (c != CHR_STAR) begin
                     if (c == CHR_NL) begin
                        res_kind[n_res[1:0]] = KIND_PROG;
                        res_val[n_res[1:0]]  = CHR_NL;
                        n_res = n_res + 3'd1;
                        pc_in = pc_in + PC_W'(1);
                     end
                     mode_in = MODE_COMMENT;
                  end
               end
               MODE_STRING: do_str = 1'b1;
               MODE_ESC: begin
                  res_kind[n_res[1:0]] = KIND_PROG;
                  res_val[n_res[1:0]]  = c;
                  n_res    = n_res + 3'd1;
                  pc_in    = pc_in + PC_W'(1);
                  rc_in    = rc_in + RC_W'(1);
                  raw_full = (rc_in >= RC_W'(STRING_BYTES - 1)) ||
                             (pc_in >= PC_W'(PROGRAM_BYTES));
                  if (raw_full) begin
                     err_hit  = 1'b1;
                     err_code = STAT_OVERSIZE;
                  end else begin
                     mode_in = MODE_STRING;
                     unique case (c)
                        CHR_N: begin
                           res_kind[n_res[1:0]] = KIND_STR;
                           res_val[n_res[1:0]]  = CHR_NL;
                           n_res = n_res + 3'd1;
                        end
                        CHR_T: begin
                           res_kind[n_res[1:0]] = KIND_STR;
                           res_val[n_res[1:0]]  = CHR_TAB;
                           n_res = n_res + 3'd1;
                        end
                        CHR_BSL, CHR_QUOTE, CHR_CR: begin
                           res_kind[n_res[1:0]] = KIND_STR;
                           res_val[n_res[1:0]]  = c;
                           n_res = n_res + 3'd1;
                        end
                        CHR_ZERO: begin
                           ov_in   = 8'd0;
                           odl_in  = 2'd2;
                           mode_in = MODE_OCT;
                        end
                        default: ;
                     endcase
                  end
               end
               MODE_OCT: begin
                  if (c >= CHR_ZERO && c <= CHR_SEVEN && odl_ff != 2'd0) begin
                     res_kind[n_res[1:0]] = KIND_PROG;
                     res_val[n_res[1:0]]  = c;
                     n_res    = n_res + 3'd1;
                     pc_in    = pc_in + PC_W'(1);
                     rc_in    = rc_in + RC_W'(1);
                     raw_full = (rc_in >= RC_W'(STRING_BYTES - 1)) ||
                                (pc_in >= PC_W'(PROGRAM_BYTES));
                     if (raw_full) begin
                        err_hit  = 1'b1;
                        err_code = STAT_OVERSIZE;
                     end else begin
                        ov_in  = {ov_ff[4:0], c[2:0]};
                        odl_in = odl_ff - 2'd1;
                        if (odl_in == 2'd0) begin
                           res_kind[n_res[1:0]] = KIND_STR;
                           res_val[n_res[1:0]]  = ov_in;
                           n_res   = n_res + 3'd1;
                           mode_in = MODE_STRING;
                        end
                     end
                  end else if (c == CHR_NUL) begin
                     err_hit  = 1'b1;
                     err_code = STAT_QUOTE;
                  end else begin
                     // short escape: flush the value, then treat the byte as text
                     res_kind[n_res[1:0]] = KIND_STR;
                     res_val[n_res[1:0]]  = ov_ff;
                     n_res   = n_res + 3'd1;
                     odl_in  = 2'd0;
                     mode_in = MODE_STRING;
                     do_str  = 1'b1;
                  end
               end
               default: begin
                  mode_in = MODE_NORMAL;
                  do_norm = 1'b1;
               end
            endcase

            if (do_norm) begin
               if (c == CHR_SPACE || c == CHR_TAB) begin
                  if (mode_in != MODE_BLANK) begin
                     res_kind[n_res[1:0]] = KIND_PROG;
                     res_val[n_res[1:0]]  = CHR_SPACE;
                     n_res = n_res + 3'd1;
                     pc_in = pc_in + PC_W'(1);
                  end
                  mode_in = MODE_BLANK;
               end else begin
                  mode_in = MODE_NORMAL;
                  if (c == CHR_SLASH) begin
                     mode_in = MODE_SLASH;
                  end else if (c == CHR_QUOTE) begin
                     res_kind[n_res[1:0]] = KIND_PROG;
                     res_val[n_res[1:0]]  = CHR_QUOTE;
                     n_res = n_res + 3'd1;
                     pc_in = pc_in + PC_W'(1);
                     if (su_ff >= SU_W'(STRING_SLOTS)) begin
                        err_hit  = 1'b1;
                        err_code = STAT_TOO_MANY;
                     end else begin
                        rc_in   = '0;
                        mode_in = MODE_STRING;
                     end
                  end else if (c == CHR_CTRLZ) begin
                     // held back; counted now, sent only if more text follows
                     held_in = 1'b1;
                     pc_in   = pc_in + PC_W'(1);
                  end else begin
                     res_kind[n_res[1:0]] = KIND_PROG;
                     res_val[n_res[1:0]]  = c;
                     n_res = n_res + 3'd1;
                     pc_in = pc_in + PC_W'(1);
                  end
               end
            end

            if (do_str) begin
               res_kind[n_res[1:0]] = KIND_PROG;
               res_val[n_res[1:0]]  = c;
               n_res    = n_res + 3'd1;
               pc_in    = pc_in + PC_W'(1);
               rc_in    = rc_in + RC_W'(1);
               raw_full = (rc_in >= RC_W'(STRING_BYTES - 1)) ||
                          (pc_in >= PC_W'(PROGRAM_BYTES));
               if (raw_full) begin
                  err_hit  = 1'b1;
                  err_code = STAT_OVERSIZE;
               end else if (c == CHR_QUOTE) begin
                  res_kind[n_res[1:0]] = KIND_SEND;
                  res_val[n_res[1:0]]  = 8'(su_ff);
                  n_res   = n_res + 3'd1;
                  su_in   = su_ff + SU_W'(1);
                  mode_in = MODE_NORMAL;
               end else if (c == CHR_BSL) begin
                  mode_in = MODE_ESC;
               end else if (c == CHR_NUL) begin
                  err_hit  = 1'b1;
                  err_code = STAT_QUOTE;
               end else begin
                  res_kind[n_res[1:0]] = KIND_STR;
                  res_val[n_res[1:0]]  = c;
                  n_res = n_res + 3'd1;
               end
            end

            // program stream full outside a string: terminate
            if (!err_hit && mode_in != MODE_STRING && mode_in != MODE_ESC &&
                mode_in != MODE_OCT && pc_in >= PC_W'(PROGRAM_BYTES - 1)) begin
               held_in = 1'b0;
               res_kind[n_res[1:0]] = KIND_END;
               res_val[n_res[1:0]]  = STAT_OK;
               n_res   = n_res + 3'd1;
               stop_in = 1'b1;
            end
         end

         // an error replaces everything else of this byte
         if (err_hit) begin
            n_res       = 3'd1;
            res_kind[0] = KIND_END;
            res_val[0]  = err_code;
            stop_in     = 1'b1;
         end
      end
   end

   assign n_push    = n_res;
   assign wr_ptr_in = wr_ptr_ff + PTR_W'(n_push);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + CNT_W'(n_push) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_NORMAL;
         pc_ff     <= '0;
         rc_ff     <= '0;
         su_ff     <= '0;
         ov_ff     <= 8'd0;
         odl_ff    <= 2'd0;
         held_ff   <= 1'b0;
         stop_ff   <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         mode_ff   <= mode_in;
         pc_ff     <= pc_in;
         rc_ff     <= rc_in;
         su_ff     <= su_in;
         ov_ff     <= ov_in;
         odl_ff    <= odl_in;
         held_ff   <= held_in;
         stop_ff   <= stop_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RES; i++) begin
         if (3'(i) < n_push) begin
            fifo_ff[wr_ptr_ff + PTR_W'(i)] <= '{kind:  res_kind[i],
                                                value: res_val[i],
                                                last:  (3'(i) == n_push - 3'd1)};
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FIFO_DEPTH))
      else $error("result queue overfilled");

   a_silent_after_stop: assert property (@(posedge clock) disable iff (reset)
      stop_ff |-> (n_push == 3'd0))
      else $error("word queued after stream end");

   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      stop_ff |=> stop_ff)
      else $error("stream end flag cleared");

   a_octal_mode: assert property (@(posedge clock) disable iff (reset)
      (odl_ff != 2'd0) |-> (mode_ff == MODE_OCT))
      else $error("octal digits pending outside octal escape");

endmodule

// File: tb/tb_source_comment_string_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_source_comment_string_filter: self-checking bench for the source filter
// Drives a directed byte sequence and then random tokens: text, blank runs,
// slashes, block comments and string literals with every escape form. Each
// accepted byte is run through a local model of the scanner and the words
// it should cause are queued, then checked in order against the result
// channel. The stream is closed by one randomly chosen ending: a clean end
// of input or one of the error paths. A few bytes sent after the stop must
// produce nothing.
// ----------------------------------------------------------------------------
module tb_source_comment_string_filter;
   import scsf_pkg::*;

   localparam int RANDOM_ITEMS = 240;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int NO_FAULT     = -1;
   localparam int SHOW_LIMIT   = 40;
   localparam logic [7:0] CHR_LOWER_A = 8'h61;

   typedef enum int {
      FIN_EOF, FIN_EOF_SLASH, FIN_EOF_COMMENT, FIN_EOF_STRING, FIN_NUL_STRING
   } fin_type;

   typedef struct packed {
      logic [7:0]      ch;
      logic            eoi;
      logic            fixed;
      logic [2:0]      n_fix;
      res_type [3:0]   w;
   } row_type;

   logic clock;
   logic reset;

   scsf_req_if req_if ();
   scsf_rsp_if rsp_if ();

   source_comment_string_filter u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   // scanner model state
   mode_type    flt_mode;
   int unsigned prog_len;
   int unsigned lit_len;
   int unsigned lit_count;
   logic [7:0]  oct_acc;
   int          oct_left;
   bit          ctrlz_pending;
   bit          flt_halted;

   res_type step_words[$];
   res_type pending_words[$];
   row_type vec_rows[$];

   bit      bursts_on = 1'b1;
   int      items_sent;
   int      words_seen;
   int      n_fail;
   int      cycle_count;
   fin_type fin;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic res_type mk_word(logic [1:0] k, logic [7:0] v, logic l);
      res_type r;
      r.kind  = k;
      r.value = v;
      r.last  = l;
      return r;
   endfunction

   function automatic row_type row(logic [7:0] ch, int n = -1,
                                   res_type a = '0, res_type b = '0);
      row_type r;
      r       = '0;
      r.ch    = ch;
      r.w[0]  = a;
      r.w[1]  = b;
      if (n >= 0) begin
         r.fixed = 1'b1;
         r.n_fix = n[2:0];
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- model
   function automatic void put_word(logic [1:0] k, logic [7:0] v);
      if (step_words.size() < MAX_RES)
         step_words.push_back(mk_word(k, v, 1'b0));
   endfunction

   function automatic void put_prog(logic [7:0] c);
      put_word(KIND_PROG, c);
      prog_len++;
   endfunction

   function automatic bit in_literal();
      return flt_mode == MODE_STRING || flt_mode == MODE_ESC || flt_mode == MODE_OCT;
   endfunction

   function automatic int text_byte(logic [7:0] c);
      if (c == CHR_SPACE || c == CHR_TAB) begin
         if (flt_mode != MODE_BLANK)
            put_prog(CHR_SPACE);
         flt_mode = MODE_BLANK;
         return NO_FAULT;
      end
      flt_mode = MODE_NORMAL;
      if (c == CHR_SLASH) begin
         flt_mode = MODE_SLASH;
      end else if (c == CHR_QUOTE) begin
         put_prog(CHR_QUOTE);
         if (lit_count >= STRING_SLOTS_DEF)
            return STAT_TOO_MANY;
         lit_len  = 0;
         flt_mode = MODE_STRING;
      end else if (c == CHR_CTRLZ) begin
         // held back, but it already takes its slot in the program count
         ctrlz_pending = 1'b1;
         prog_len++;
      end else begin
         put_prog(c);
      end
      return NO_FAULT;
   endfunction

   function automatic bit raw_full(logic [7:0] c);
      put_prog(c);
      lit_len++;
      return lit_len >= STRING_BYTES_DEF - 1 || prog_len >= PROGRAM_BYTES_DEF;
   endfunction

   function automatic int lit_byte(logic [7:0] c);
      if (raw_full(c))
         return STAT_OVERSIZE;
      if (c == CHR_QUOTE) begin
         put_word(KIND_SEND, lit_count[7:0]);
         lit_count++;
         flt_mode = MODE_NORMAL;
      end else if (c == CHR_BSL) begin
         flt_mode = MODE_ESC;
      end else if (c == CHR_NUL) begin
         return STAT_QUOTE;
      end else begin
         put_word(KIND_STR, c);
      end
      return NO_FAULT;
   endfunction

   function automatic int esc_byte(logic [7:0] c);
      if (raw_full(c))
         return STAT_OVERSIZE;
      flt_mode = MODE_STRING;
      case (c)
         CHR_N:     put_word(KIND_STR, CHR_NL);
         CHR_T:     put_word(KIND_STR, CHR_TAB);
         CHR_BSL:   put_word(KIND_STR, CHR_BSL);
         CHR_QUOTE: put_word(KIND_STR, CHR_QUOTE);
         CHR_CR:    put_word(KIND_STR, CHR_CR);
         CHR_ZERO: begin
            oct_acc  = '0;
            oct_left = 2;
            flt_mode = MODE_OCT;
         end
         default: ;
      endcase
      return NO_FAULT;
   endfunction

   function automatic int oct_byte(logic [7:0] c);
      if (c >= CHR_ZERO && c <= CHR_SEVEN && oct_left > 0) begin
         if (raw_full(c))
            return STAT_OVERSIZE;
         oct_acc = 8'(oct_acc * 8 + (c - CHR_ZERO));
         oct_left--;
         if (oct_left == 0) begin
            put_word(KIND_STR, oct_acc);
            flt_mode = MODE_STRING;
         end
         return NO_FAULT;
      end
      if (c == CHR_NUL)
         return STAT_QUOTE;
      // short escape: flush the value, then treat c as a plain string byte
      put_word(KIND_STR, oct_acc);
      oct_left = 0;
      flt_mode = MODE_STRING;
      return lit_byte(c);
   endfunction

   function automatic int scan_byte(logic [7:0] c);
      case (flt_mode)
         MODE_SLASH: begin
            if (c == CHR_STAR) begin
               flt_mode = MODE_COMMENT;
               return NO_FAULT;
            end
            put_prog(CHR_SLASH);
            flt_mode = MODE_NORMAL;
            return text_byte(c);
         end
         MODE_COMMENT: begin
            if (c == CHR_STAR)
               flt_mode = MODE_STAR;
            else if (c == CHR_NL)
               put_prog(CHR_NL);
            return NO_FAULT;
         end
         MODE_STAR: begin
            // closing slash is swallowed; further stars keep the close armed
            if (c == CHR_SLASH) begin
               flt_mode = MODE_NORMAL;
            end else if (c != CHR_STAR) begin
               if (c == CHR_NL)
                  put_prog(CHR_NL);
               flt_mode = MODE_COMMENT;
            end
            return NO_FAULT;
         end
         MODE_STRING: return lit_byte(c);
         MODE_ESC:    return esc_byte(c);
         MODE_OCT:    return oct_byte(c);
         default:     return text_byte(c);
      endcase
   endfunction

   function automatic void filter_step(logic [7:0] c, logic eoi);
      int fault;
      fault = NO_FAULT;
      step_words.delete();
      if (flt_halted)
         return;
      if (eoi) begin
         if (flt_mode == MODE_COMMENT || flt_mode == MODE_STAR)
            fault = STAT_UNBAL;
         else if (in_literal())
            fault = STAT_QUOTE;
         else if (flt_mode == MODE_SLASH)
            put_prog(CHR_SLASH);
         if (fault == NO_FAULT)
            put_word(KIND_END, STAT_OK);
         ctrlz_pending = 1'b0;
         flt_halted    = 1'b1;
      end else begin
         if (ctrlz_pending) begin
            put_word(KIND_PROG, CHR_CTRLZ);
            ctrlz_pending = 1'b0;
         end
         fault = scan_byte(c);
         if (fault == NO_FAULT && !in_literal() && prog_len >= PROGRAM_BYTES_DEF - 1) begin
            ctrlz_pending = 1'b0;
            put_word(KIND_END, STAT_OK);
            flt_halted = 1'b1;
         end
      end
      if (fault != NO_FAULT) begin
         step_words.delete();
         put_word(KIND_END, fault[7:0]);
         flt_halted = 1'b1;
      end
      if (step_words.size() > 0)
         step_words[step_words.size() - 1].last = 1'b1;
   endfunction

   // -------------------------------------------------------------- driving
   task automatic feed_row(row_type r);
      int gap;
      if (bursts_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 19);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.src_byte     <= r.ch;
      req_if.end_of_input <= r.eoi;
      do @(posedge clock); while (!req_if.ready);
      if (!flt_halted)
         items_sent++;
      filter_step(r.ch, r.eoi);
      if (r.fixed) begin
         for (int i = 0; i < r.n_fix; i++)
            pending_words.push_back(r.w[i]);
      end else begin
         foreach (step_words[i])
            pending_words.push_back(step_words[i]);
      end
   endtask

   task automatic feed(logic [7:0] c, logic eoi = 1'b0);
      row_type r;
      r     = row(c);
      r.eoi = eoi;
      feed_row(r);
   endtask

   function automatic logic [7:0] text_noise();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (c == CHR_SLASH || c == CHR_QUOTE);
      return c;
   endfunction

   function automatic logic [7:0] lit_plain();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255)); while (c == CHR_QUOTE || c == CHR_BSL);
      return c;
   endfunction

   // bring the scanner back to plain text before the next token
   task automatic settle();
      while (!flt_halted && flt_mode != MODE_NORMAL && flt_mode != MODE_BLANK) begin
         case (flt_mode)
            MODE_COMMENT, MODE_STAR: begin
               feed(CHR_STAR);
               feed(CHR_SLASH);
            end
            MODE_ESC:   feed(CHR_N);
            MODE_SLASH: feed(CHR_LOWER_A);
            default:    feed(CHR_QUOTE);
         endcase
      end
   endtask

   task automatic send_token();
      int pick, n, k;
      logic [7:0] c, prev;
      settle();
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1: begin
            n = $urandom_range(1, 6);
            if ($urandom_range(0, 3) == 0)
               feed(CHR_CTRLZ);
            repeat (n) feed(text_noise());
         end
         2: begin
            n = $urandom_range(1, 4);
            repeat (n) feed($urandom_range(0, 1) ? CHR_SPACE : CHR_TAB);
         end
         3: begin
            if ($urandom_range(0, 1))
               feed(CHR_CTRLZ);
            feed(CHR_SLASH);
            do c = text_noise(); while (c == CHR_STAR);
            feed(c);
         end
         4, 5: begin
            feed(CHR_SLASH);
            feed(CHR_STAR);
            n    = $urandom_range(0, 8);
            prev = CHR_NUL;
            repeat (n) begin
               if ($urandom_range(0, 3) == 0)
                  c = CHR_NL;
               else
                  do
                     c = 8'($urandom_range(0, 255));
                  while (prev == CHR_STAR && c == CHR_SLASH);
               feed(c);
               prev = c;
            end
            n = $urandom_range(1, 3);
            repeat (n) feed(CHR_STAR);
            feed(CHR_SLASH);
         end
         default: begin
            feed(CHR_QUOTE);
            n = $urandom_range(0, 8);
            repeat (n) begin
               case ($urandom_range(0, 5))
                  0, 1: feed(lit_plain());
                  2: begin
                     feed(CHR_BSL);
                     case ($urandom_range(0, 4))
                        0: feed(CHR_N);
                        1: feed(CHR_T);
                        2: feed(CHR_BSL);
                        3: feed(CHR_QUOTE);
                        default: feed(CHR_CR);
                     endcase
                  end
                  3: begin
                     feed(CHR_BSL);
                     feed(8'($urandom_range(0, 255)));
                  end
                  default: begin
                     feed(CHR_BSL);
                     feed(CHR_ZERO);
                     k = $urandom_range(0, 2);
                     repeat (k) feed(CHR_ZERO + 8'($urandom_range(0, 7)));
                  end
               endcase
            end
            feed(CHR_QUOTE);
         end
      endcase
   endtask

   // ------------------------------------------------------------ rsp stall
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (bursts_on && $urandom_range(0, 4) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(0, 15)) @(posedge clock);
      end
   end

   // -------------------------------------------------------------- checker
   always @(posedge clock) begin
      res_type got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = mk_word(rsp_if.out_kind, rsp_if.out_value, rsp_if.out_last);
         words_seen++;
         if (pending_words.size() == 0) begin
            n_fail++;
            if (n_fail <= SHOW_LIMIT)
               $display("%0t unexpected word: expected none, got %0d/%02h/%0d",
                        $time, got.kind, got.value, got.last);
         end else begin
            want = pending_words.pop_front();
            if (got.kind !== want.kind || got.value !== want.value ||
                got.last !== want.last) begin
               n_fail++;
               if (n_fail <= SHOW_LIMIT)
                  $display("%0t mismatch: expected %0d/%02h/%0d, got %0d/%02h/%0d",
                           $time, want.kind, want.value, want.last,
                           got.kind, got.value, got.last);
            end
         end
      end
   end

   // ------------------------------------------------------------- watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   // ----------------------------------------------------------------- main
   initial begin
      int dir_count;
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.src_byte     = '0;
      req_if.end_of_input = 1'b0;
      flt_mode      = MODE_NORMAL;
      prog_len      = 0;
      lit_len       = 0;
      lit_count     = 0;
      oct_acc       = '0;
      oct_left      = 0;
      ctrlz_pending = 1'b0;
      flt_halted    = 1'b0;

      // directed words; typed results where they are obvious
      vec_rows.push_back(row(8'hFF, 1, mk_word(KIND_PROG, 8'hFF, 1'b1)));
      vec_rows.push_back(row(CHR_NUL, 1, mk_word(KIND_PROG, CHR_NUL, 1'b1)));
      vec_rows.push_back(row(CHR_SPACE, 1, mk_word(KIND_PROG, CHR_SPACE, 1'b1)));
      vec_rows.push_back(row(CHR_TAB, 0));
      vec_rows.push_back(row(CHR_SLASH, 0));
      vec_rows.push_back(row(CHR_STAR, 0));
      vec_rows.push_back(row(CHR_NL, 1, mk_word(KIND_PROG, CHR_NL, 1'b1)));
      // star run before the closing slash
      vec_rows.push_back(row(CHR_STAR));
      vec_rows.push_back(row(CHR_STAR));
      vec_rows.push_back(row(CHR_SLASH));
      vec_rows.push_back(row(CHR_SLASH));
      vec_rows.push_back(row(CHR_LOWER_A));
      // held control-Z released by the opening quote
      vec_rows.push_back(row(CHR_CTRLZ));
      vec_rows.push_back(row(CHR_QUOTE));
      vec_rows.push_back(row(CHR_BSL));
      vec_rows.push_back(row(CHR_N));
      vec_rows.push_back(row(CHR_BSL));
      vec_rows.push_back(row(CHR_CR));
      vec_rows.push_back(row(CHR_BSL));
      vec_rows.push_back(row(CHR_NUL));
      // short octal escape, next word kept as a plain string byte
      vec_rows.push_back(row(CHR_BSL));
      vec_rows.push_back(row(CHR_ZERO));
      vec_rows.push_back(row(CHR_SEVEN));
      vec_rows.push_back(row(CHR_LOWER_A + 8'd16));
      vec_rows.push_back(row(CHR_BSL));
      vec_rows.push_back(row(CHR_ZERO));
      vec_rows.push_back(row(CHR_ZERO + 8'd1));
      vec_rows.push_back(row(CHR_ZERO + 8'd2));
      vec_rows.push_back(row(CHR_QUOTE));
      dir_count = vec_rows.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (vec_rows[i])
         feed_row(vec_rows[i]);

      while (items_sent < dir_count + RANDOM_ITEMS)
         send_token();

      // closing phase runs flat out
      bursts_on = 1'b0;
      settle();
      fin = fin_type'($urandom_range(0, 4));
      case (fin)
         FIN_EOF: begin
            if ($urandom_range(0, 1))
               feed(CHR_CTRLZ);
         end
         FIN_EOF_SLASH: feed(CHR_SLASH);
         FIN_EOF_COMMENT: begin
            feed(CHR_SLASH);
            feed(CHR_STAR);
            if ($urandom_range(0, 1))
               feed(CHR_STAR);
         end
         FIN_EOF_STRING: begin
            feed(CHR_QUOTE);
            feed(lit_plain());
            case ($urandom_range(0, 2))
               0: feed(CHR_BSL);
               1: begin
                  feed(CHR_BSL);
                  feed(CHR_ZERO);
               end
               default: ;
            endcase
         end
         FIN_NUL_STRING: begin
            feed(CHR_QUOTE);
            if ($urandom_range(0, 1)) begin
               feed(CHR_BSL);
               feed(CHR_ZERO);
               if ($urandom_range(0, 1))
                  feed(CHR_SEVEN);
            end
            feed(CHR_NUL);
         end
         default: ;
      endcase
      feed(8'($urandom_range(0, 255)), 1'b1);

      // stream is stopped; these must be swallowed
      repeat (8) feed(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      req_if.valid <= 1'b0;

      while (pending_words.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);

      $display("Run: %0d source words scanned, %0d result words checked, %0d strings closed",
               items_sent, words_seen, lit_count);
      $display("Stream closed by %s", fin.name());
      if (n_fail == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/scsf_pkg.sv
sv/scsf_req_if.sv
sv/scsf_rsp_if.sv
sv/source_comment_string_filter.sv
tb/tb_source_comment_string_filter.sv
